FILE: hw/rtl/tsp_pkg.sv
// ----------------------------------------------------------------------------
// Torus surface point package
// Shared types, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package tsp_pkg;

   localparam int ANGLE_BITS_DEFAULT  = 16;
   localparam int RADIUS_BITS_DEFAULT = 16;

   localparam int CORDIC_STEPS = 24;
   localparam int VEC_W        = 34;
   localparam int TRIG_W       = 24;
   localparam int TRIG_FRAC    = 20;

   localparam logic signed [VEC_W-1:0] INV_GAIN_Q30 = 34'sd652032874;

   localparam logic [0:0] CSR_MAJOR = 1'b0;
   localparam logic [0:0] CSR_MINOR = 1'b1;

   localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
   };

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [VEC_W-1:0] z;
      logic [1:0]              quarter;
   } cordic_vec_type;

endpackage

FILE: hw/rtl/tsp_cordic_cell.sv
// ----------------------------------------------------------------------------
// Torus surface point CORDIC cell
// One rotation step; registers the rotated vector for the next cell.
// ----------------------------------------------------------------------------
module tsp_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                    clock,
   input  logic                    en,
   input  tsp_pkg::cordic_vec_type prev_vec,
   output tsp_pkg::cordic_vec_type next_vec
);

   tsp_pkg::cordic_vec_type vec_ff;
   tsp_pkg::cordic_vec_type vec_in;
   logic signed [tsp_pkg::VEC_W-1:0] dx;
   logic signed [tsp_pkg::VEC_W-1:0] dy;
   logic signed [tsp_pkg::VEC_W-1:0] angle;

   always_comb begin
      dx     = prev_vec.y >>> STAGE;
      dy     = prev_vec.x >>> STAGE;
      angle  = $signed({2'b00, tsp_pkg::ATAN_TURN[STAGE]});
      vec_in = prev_vec;
      if (!prev_vec.z[tsp_pkg::VEC_W-1]) begin
         vec_in.x = prev_vec.x - dx;
         vec_in.y = prev_vec.y + dy;
         vec_in.z = prev_vec.z - angle;
      end else begin
         vec_in.x = prev_vec.x + dx;
         vec_in.y = prev_vec.y - dy;
         vec_in.z = prev_vec.z + angle;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff <= vec_in;
      end
   end

   assign next_vec = vec_ff;

endmodule

FILE: hw/rtl/torus_surface_point_top.sv
// ----------------------------------------------------------------------------
// Torus surface point top level
// The pipeline is 24 CORDIC cells, then trig rounding, ring, product
// and output stages. Throughput is one request per cycle; the whole chain
// advances whenever the output register is empty or being taken.
// Reset clears the pipeline valid bits and both radius registers to zero.
// ----------------------------------------------------------------------------
module torus_surface_point_top #(
   parameter int ANGLE_BITS  = tsp_pkg::ANGLE_BITS_DEFAULT,
   parameter int RADIUS_BITS = tsp_pkg::RADIUS_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [ANGLE_BITS-1:0]  req_turn_u,
   input  logic [ANGLE_BITS-1:0]  req_turn_v,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [RADIUS_BITS+1:0] rsp_point_x,
   output logic [RADIUS_BITS:0]   rsp_point_y,
   output logic [RADIUS_BITS+1:0] rsp_point_z,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [0:0]             csr_index,
   input  logic [RADIUS_BITS-1:0] csr_data
);

   localparam int STEPS  = tsp_pkg::CORDIC_STEPS;
   localparam int VW     = tsp_pkg::VEC_W;
   localparam int TW     = tsp_pkg::TRIG_W;
   localparam int RB     = RADIUS_BITS;
   localparam int NVALID = STEPS + 4;
   localparam int RING_W = RB + 11;
   localparam int PY_W   = RB + 6;
   localparam int PROD_W = RING_W + TW;
   localparam int OSUM_W = RB + 37;
   localparam int OV_W   = RB + 9;

   logic en;
   logic [NVALID-1:0] valid_ff;
   logic [RB-1:0] major_ff;
   logic [RB-1:0] minor_ff;

   tsp_pkg::cordic_vec_type chain_u [STEPS+1];
   tsp_pkg::cordic_vec_type chain_v [STEPS+1];

   logic signed [TW-1:0] cu_ff, su_ff, cv_ff, sv_ff;
   logic signed [TW-1:0] cu_in, su_in, cv_in, sv_in;
   logic signed [RING_W-1:0] ring_ff, ring_in;
   logic signed [TW-1:0] cv2_ff, sv2_ff;
   logic signed [PY_W-1:0] py_ff, py_in, py2_ff;
   logic signed [PROD_W-1:0] prodx_ff, prodz_ff;
   logic [RB+1:0] px_in, pz_in;
   logic [RB:0] pyo_in;
   logic [RB+1:0] px_ff, pz_ff;
   logic [RB:0] pyo_ff;

   assign en        = !valid_ff[NVALID-1] || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;
   assign rsp_valid = valid_ff[NVALID-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         major_ff <= '0;
         minor_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            tsp_pkg::CSR_MAJOR: major_ff <= csr_data;
            tsp_pkg::CSR_MINOR: minor_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NVALID-2:0], req_valid};
      end
   end

   function automatic tsp_pkg::cordic_vec_type start_vec(input logic [ANGLE_BITS-1:0] turn);
      logic [31:0] t32;
      logic [31:0] biased;
      logic [31:0] resid;
      tsp_pkg::cordic_vec_type v;
      t32       = {turn, {(32-ANGLE_BITS){1'b0}}};
      biased    = t32 + 32'h2000_0000;
      v.quarter = biased[31:30];
      resid     = t32 - {biased[31:30], 30'b0};
      v.x       = tsp_pkg::INV_GAIN_Q30;
      v.y       = '0;
      v.z       = {{(VW-32){resid[31]}}, resid};
      return v;
   endfunction

   assign chain_u[0] = start_vec(req_turn_u);
   assign chain_v[0] = start_vec(req_turn_v);

   for (genvar i = 0; i < STEPS; i++) begin : g_cell
      tsp_cordic_cell #(.STAGE(i)) u_cell_u (
         .clock(clock), .en(en), .prev_vec(chain_u[i]), .next_vec(chain_u[i+1])
      );
      tsp_cordic_cell #(.STAGE(i)) u_cell_v (
         .clock(clock), .en(en), .prev_vec(chain_v[i]), .next_vec(chain_v[i+1])
      );
   end

   function automatic logic [2*TW-1:0] finish_trig(input tsp_pkg::cordic_vec_type v);
      logic signed [VW-1:0] cx;
      logic signed [VW-1:0] sy;
      logic signed [TW-1:0] c;
      logic signed [TW-1:0] s;
      logic signed [TW-1:0] co;
      logic signed [TW-1:0] so;
      cx = (v.x + 34'sd512) >>> 10;
      sy = (v.y + 34'sd512) >>> 10;
      c  = cx[TW-1:0];
      s  = sy[TW-1:0];
      case (v.quarter)
         2'd1: begin co = -s; so = c;  end
         2'd2: begin co = -c; so = -s; end
         2'd3: begin co = s;  so = -c; end
         default: begin co = c; so = s; end
      endcase
      return {co, so};
   endfunction

   logic signed [RB+25:0] ring_sum, py_sum;
   logic signed [RB+24:0] mul_cu, mul_su;

   always_comb begin
      {cu_in, su_in} = finish_trig(chain_u[STEPS]);
      {cv_in, sv_in} = finish_trig(chain_v[STEPS]);
      mul_cu   = $signed({1'b0, minor_ff}) * cu_ff;
      mul_su   = $signed({1'b0, minor_ff}) * su_ff;
      ring_sum = $signed({6'b0, major_ff, 20'b0}) + {mul_cu[RB+24], mul_cu}
                 + $signed((RB+26)'(2048));
      py_sum   = $signed({6'b0, minor_ff, 20'b0}) + {mul_su[RB+24], mul_su}
                 + $signed((RB+26)'(524288));
      ring_in  = ring_sum[RING_W+11:12];
      py_in    = py_sum[RB+25:20];
   end

   logic signed [OSUM_W-1:0] ox_sum, oz_sum, offset;
   logic signed [OV_W-1:0] ox, oz;

   always_comb begin
      offset = $signed({8'b0, {1'b0, major_ff} + {1'b0, minor_ff}, 28'b0})
               + $signed(OSUM_W'(134217728));
      ox_sum = {{(OSUM_W-PROD_W){prodx_ff[PROD_W-1]}}, prodx_ff} + offset;
      oz_sum = {{(OSUM_W-PROD_W){prodz_ff[PROD_W-1]}}, prodz_ff} + offset;
      ox     = ox_sum[OSUM_W-1:28];
      oz     = oz_sum[OSUM_W-1:28];
      if (ox[OV_W-1]) begin
         px_in = '0;
      end else if (ox[OV_W-2:RB+2] != '0) begin
         px_in = '1;
      end else begin
         px_in = ox[RB+1:0];
      end
      if (oz[OV_W-1]) begin
         pz_in = '0;
      end else if (oz[OV_W-2:RB+2] != '0) begin
         pz_in = '1;
      end else begin
         pz_in = oz[RB+1:0];
      end
      if (py2_ff[PY_W-1]) begin
         pyo_in = '0;
      end else if (py2_ff[PY_W-2:RB+1] != '0) begin
         pyo_in = '1;
      end else begin
         pyo_in = py2_ff[RB:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cu_ff    <= cu_in;
         su_ff    <= su_in;
         cv_ff    <= cv_in;
         sv_ff    <= sv_in;
         ring_ff  <= ring_in;
         py_ff    <= py_in;
         cv2_ff   <= cv_ff;
         sv2_ff   <= sv_ff;
         prodx_ff <= ring_ff * cv2_ff;
         prodz_ff <= ring_ff * sv2_ff;
         py2_ff   <= py_ff;
         px_ff    <= px_in;
         pz_ff    <= pz_in;
         pyo_ff   <= pyo_in;
      end
   end

   assign rsp_point_x = px_ff;
   assign rsp_point_y = pyo_ff;
   assign rsp_point_z = pz_ff;

   a_pipe_reaches_output: assert property (@(posedge clock) disable iff (reset)
      valid_ff[NVALID-2] && en |=> rsp_valid)
      else $error("request in last stage did not reach the output");

   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("output valid after reset");

   a_stall_holds_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_point_x)
      && $stable(rsp_point_z))
      else $error("stalled result changed");

endmodule
